### design/lzsswd_pkg.sv
// lzsswd_pkg: shared constants, state type and window request struct for the
// lzss window decoder. No dependencies; used by lzsswd_window and the core.
package lzsswd_pkg;

    localparam int WINDOW_DEPTH         = 4096;
    localparam int WIN_AW               = $clog2(WINDOW_DEPTH);
    localparam int INDEX_BITS_DEF       = 12;
    localparam int LENGTH_BITS_DEF      = 4;
    localparam int MIN_MATCH_OFFSET_DEF = 1;

    localparam int LIT_BITS   = 8;
    localparam int RESULT_CAP = 17;
    localparam int RES_W      = $clog2(RESULT_CAP + 1);
    localparam int START_POS  = 1;
    localparam int END_INDEX  = 0;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_COPY
    } t_state;

    // one write port and one read port of the history window
    typedef struct packed {
        logic              wr_en;
        logic [WIN_AW-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [WIN_AW-1:0] rd_addr;
    } t_win_req;

endpackage

### design/lzsswd_window.sv
// lzsswd_window: history window memory, one write and one registered read per
// cycle, with write-to-read forwarding. Depends on lzsswd_pkg.
module lzsswd_window (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lzsswd_pkg::t_win_req i_req,
    output logic [7:0]           o_rd_data
);
    import lzsswd_pkg::*;

    logic [7:0] r_mem [WINDOW_DEPTH];
    logic [7:0] r_rd_data;
    logic [7:0] r_fwd_data;
    logic       r_fwd_hit;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data  <= r_mem[i_req.rd_addr];
            r_fwd_data <= i_req.wr_data;
        end
    end

    // a read of the entry written in the same cycle must see the new byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (i_req.rd_en) begin
            r_fwd_hit <= i_req.wr_en && (i_req.wr_addr == i_req.rd_addr);
        end
    end

    assign o_rd_data = r_fwd_hit ? r_fwd_data : r_rd_data;

endmodule

### design/lzss_window_decoder_core.sv
// lzss_window_decoder_core: top level of the lzss decoder with a 4096-byte
// history window. Depends on lzsswd_pkg and lzsswd_window.
//
// Compressed bytes enter on s_axis one at a time and are read msb first. After
// reset the window is swept to zero, all 4096 entries, with s_axis_tready low.
// One input byte is handled at a time: it is taken, then each literal is
// emitted, a match is opened and each copied byte is emitted (the window's
// single read port feeds one byte per cycle while m_axis does not stall), and
// the end marker is emitted or the byte closes out; a byte without tuser that
// arrives after the end is taken and ignored. tuser on s_axis marks the first
// byte of a new stream. At most 17 results follow one byte.
module lzss_window_decoder_core #(
    parameter int INDEX_BITS       = lzsswd_pkg::INDEX_BITS_DEF,
    parameter int LENGTH_BITS      = lzsswd_pkg::LENGTH_BITS_DEF,
    parameter int MIN_MATCH_OFFSET = lzsswd_pkg::MIN_MATCH_OFFSET_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tuser,   // [0] start_req
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [0] byte_valid, [1] stream_end
    output logic       m_axis_tlast
);
    import lzsswd_pkg::*;

    localparam int TOK_BITS = 1 + INDEX_BITS + LENGTH_BITS;
    localparam int LIT_TOK  = 1 + LIT_BITS;
    localparam int TOK_MAX  = (TOK_BITS > LIT_TOK) ? TOK_BITS : LIT_TOK;
    localparam int PEND_W   = TOK_MAX + LIT_BITS - 1;
    localparam int CNT_W    = $clog2(PEND_W + 1);
    localparam int LEN_MAX  = (1 << LENGTH_BITS) + MIN_MATCH_OFFSET;
    localparam int LEN_W    = $clog2(LEN_MAX + 1);
    localparam int IDX_EXT  = (INDEX_BITS > WIN_AW) ? INDEX_BITS : WIN_AW;

    // true when the left-aligned bits hold a whole token that gives a result
    function automatic logic yields(input logic [PEND_W-1:0] bits,
                                    input logic [CNT_W-1:0]  cnt);
        logic [INDEX_BITS-1:0] idx;
        logic                  ok;
        idx = bits[PEND_W-2 -: INDEX_BITS];
        if (cnt == '0) begin
            ok = 1'b0;
        end else if (bits[PEND_W-1]) begin
            ok = (cnt >= CNT_W'(LIT_TOK));
        end else begin
            ok = (cnt >= CNT_W'(1 + INDEX_BITS)) &&
                 ((idx == INDEX_BITS'(END_INDEX)) || (cnt >= CNT_W'(TOK_BITS)));
        end
        return ok;
    endfunction

    t_state             r_state, n_state;
    logic [PEND_W-1:0]  r_bits, n_bits;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [WIN_AW-1:0]  r_wp, n_wp;
    logic               r_stopped, n_stopped;
    logic [RES_W-1:0]   r_k, n_k;
    logic [WIN_AW-1:0]  r_src, n_src;
    logic [LEN_W-1:0]   r_len_left, n_len_left;
    logic [WIN_AW-1:0]  r_clr_addr, n_clr_addr;

    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_bvalid;
    logic               r_out_end;
    logic               r_out_last;

    t_win_req           win_req;
    logic [7:0]         win_rd_data;

    logic               emit;
    logic [7:0]         em_byte;
    logic               em_bvalid;
    logic               em_end;
    logic               em_last;

    // decode view of the pending bits
    logic                   out_ok;
    logic                   in_acc;
    logic                   in_run;
    logic                   dec_yield;
    logic                   dec_flag;
    logic [INDEX_BITS-1:0]  dec_idx;
    logic                   dec_is_end;
    logic [IDX_EXT-1:0]     dec_idx_ext;
    logic [WIN_AW-1:0]      dec_addr;
    logic [LENGTH_BITS-1:0] dec_len;
    logic                   cap_hit;
    logic                   cap_next;
    logic                   copy_more;
    logic [PEND_W-1:0]      lit_rest_bits;
    logic [CNT_W-1:0]       lit_rest_cnt;
    logic [PEND_W-1:0]      eff_bits;
    logic [CNT_W-1:0]       eff_cnt;
    logic [PEND_W-1:0]      app_bits;

    assign out_ok        = !r_out_valid || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_run        = s_axis_tuser || !r_stopped;
    assign dec_yield     = yields(r_bits, r_cnt);
    assign dec_flag      = r_bits[PEND_W-1];
    assign dec_idx       = r_bits[PEND_W-2 -: INDEX_BITS];
    assign dec_is_end    = (dec_idx == INDEX_BITS'(END_INDEX));
    assign dec_idx_ext   = IDX_EXT'(dec_idx);
    assign dec_addr      = dec_idx_ext[WIN_AW-1:0];
    assign dec_len       = r_bits[PEND_W-2-INDEX_BITS -: LENGTH_BITS];
    assign cap_hit       = (r_k == RES_W'(RESULT_CAP));
    assign cap_next      = (r_k == RES_W'(RESULT_CAP - 1));
    assign copy_more     = (r_len_left > LEN_W'(1)) && !cap_next;
    assign lit_rest_bits = r_bits << LIT_TOK;
    assign lit_rest_cnt  = r_cnt - CNT_W'(LIT_TOK);
    assign eff_bits      = s_axis_tuser ? '0 : r_bits;
    assign eff_cnt       = s_axis_tuser ? '0 : r_cnt;
    assign app_bits      = {s_axis_tdata, {(PEND_W - LIT_BITS){1'b0}}} >> eff_cnt;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == WIN_AW'(WINDOW_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid && in_run) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (cap_hit || !dec_yield) begin
                    n_state = S_IDLE;
                end else if (!dec_flag) begin
                    if (dec_is_end) begin
                        if (out_ok) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_state = S_COPY;
                    end
                end
            end
            S_COPY: begin
                if (out_ok && !copy_more) begin
                    n_state = S_DECODE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and handshake outputs
    always_comb begin
        n_bits        = r_bits;
        n_cnt         = r_cnt;
        n_wp          = r_wp;
        n_stopped     = r_stopped;
        n_k           = r_k;
        n_src         = r_src;
        n_len_left    = r_len_left;
        n_clr_addr    = r_clr_addr;
        s_axis_tready = 1'b0;
        win_req       = '0;
        emit          = 1'b0;
        em_byte       = '0;
        em_bvalid     = 1'b0;
        em_end        = 1'b0;
        em_last       = 1'b0;
        case (r_state)
            S_CLEAR: begin
                win_req.wr_en   = 1'b1;
                win_req.wr_addr = r_clr_addr;
                win_req.wr_data = '0;
                n_clr_addr      = r_clr_addr + WIN_AW'(1);
            end
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (in_acc) begin
                    if (s_axis_tuser) begin
                        n_wp      = WIN_AW'(START_POS);
                        n_stopped = 1'b0;
                        n_bits    = '0;
                        n_cnt     = '0;
                    end
                    if (in_run) begin
                        n_bits = eff_bits | app_bits;
                        n_cnt  = eff_cnt + CNT_W'(LIT_BITS);
                        n_k    = '0;
                    end
                end
            end
            S_DECODE: begin
                if (!cap_hit && dec_yield) begin
                    if (dec_flag) begin
                        if (out_ok) begin
                            emit            = 1'b1;
                            em_byte         = r_bits[PEND_W-2 -: LIT_BITS];
                            em_bvalid       = 1'b1;
                            em_last         = cap_next || !yields(lit_rest_bits, lit_rest_cnt);
                            win_req.wr_en   = 1'b1;
                            win_req.wr_addr = r_wp;
                            win_req.wr_data = em_byte;
                            n_wp            = r_wp + WIN_AW'(1);
                            n_k             = r_k + RES_W'(1);
                            n_bits          = lit_rest_bits;
                            n_cnt           = lit_rest_cnt;
                        end
                    end else if (dec_is_end) begin
                        if (out_ok) begin
                            // rest of the byte after the end marker is dropped
                            emit      = 1'b1;
                            em_end    = 1'b1;
                            em_last   = 1'b1;
                            n_k       = r_k + RES_W'(1);
                            n_stopped = 1'b1;
                            n_bits    = '0;
                            n_cnt     = '0;
                        end
                    end else begin
                        win_req.rd_en   = 1'b1;
                        win_req.rd_addr = dec_addr;
                        n_src           = dec_addr + WIN_AW'(1);
                        n_len_left      = LEN_W'(dec_len) + LEN_W'(MIN_MATCH_OFFSET + 1);
                        n_bits          = r_bits << TOK_BITS;
                        n_cnt           = r_cnt - CNT_W'(TOK_BITS);
                    end
                end
            end
            S_COPY: begin
                if (out_ok) begin
                    emit            = 1'b1;
                    em_byte         = win_rd_data;
                    em_bvalid       = 1'b1;
                    em_last         = cap_next || ((r_len_left == LEN_W'(1)) && !dec_yield);
                    win_req.wr_en   = 1'b1;
                    win_req.wr_addr = r_wp;
                    win_req.wr_data = win_rd_data;
                    n_wp            = r_wp + WIN_AW'(1);
                    n_k             = r_k + RES_W'(1);
                    n_len_left      = r_len_left - LEN_W'(1);
                    // next source byte may be the one written right now
                    if (copy_more) begin
                        win_req.rd_en   = 1'b1;
                        win_req.rd_addr = r_src;
                        n_src           = r_src + WIN_AW'(1);
                    end
                end
            end
            default: begin
                n_k = r_k;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_bits     <= '0;
            r_cnt      <= '0;
            r_wp       <= WIN_AW'(START_POS);
            r_stopped  <= 1'b0;
            r_k        <= '0;
            r_len_left <= '0;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_bits     <= n_bits;
            r_cnt      <= n_cnt;
            r_wp       <= n_wp;
            r_stopped  <= n_stopped;
            r_k        <= n_k;
            r_len_left <= n_len_left;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src <= n_src;
    end

    // output register, reloaded in the cycle it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte   <= em_byte;
            r_out_bvalid <= em_bvalid;
            r_out_end    <= em_end;
            r_out_last   <= em_last;
        end
    end

    lzsswd_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (win_req),
        .o_rd_data (win_rd_data)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tuser  = {r_out_end, r_out_bvalid};
    assign m_axis_tlast  = r_out_last;

endmodule
